// File: rtl/cmfuv_pkg.sv
`timescale 1ns / 1ps
// cmfuv_pkg: shared widths, transaction types and pipeline stage type
// for the cube map face and uv select block; no dependencies

package cmfuv_pkg;

   localparam int COORD_BITS = 16;
   localparam int FRAC_BITS  = 16;

   localparam logic [2:0] FACE_POS_X = 3'd0;
   localparam logic [2:0] FACE_NEG_X = 3'd1;
   localparam logic [2:0] FACE_POS_Y = 3'd2;
   localparam logic [2:0] FACE_NEG_Y = 3'd3;
   localparam logic [2:0] FACE_POS_Z = 3'd4;
   localparam logic [2:0] FACE_NEG_Z = 3'd5;

   typedef struct packed {
      logic signed [COORD_BITS-1:0] dir_x;
      logic signed [COORD_BITS-1:0] dir_y;
      logic signed [COORD_BITS-1:0] dir_z;
   } req_type;

   typedef struct packed {
      logic [2:0]           face_index;
      logic [FRAC_BITS-1:0] tex_u;
      logic [FRAC_BITS-1:0] tex_v;
      logic                 zero_vector;
   } rsp_type;

   // state carried from cell to cell of the division chain
   typedef struct packed {
      logic [2:0]            face;
      logic                  zero;
      logic                  sat_u;
      logic                  sat_v;
      logic [COORD_BITS:0]   den;
      logic [COORD_BITS:0]   rem_u;
      logic [COORD_BITS:0]   rem_v;
      logic [FRAC_BITS-1:0]  quo_u;
      logic [FRAC_BITS-1:0]  quo_v;
   } stage_type;

endpackage

// File: rtl/cmfuv_face_sel.sv
`timescale 1ns / 1ps
// cmfuv_face_sel: picks the face by largest magnitude and registers the
// numerators and divisor for the division chain; uses cmfuv_pkg

module cmfuv_face_sel (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cmfuv_pkg::req_type    in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cmfuv_pkg::stage_type  out_data
);

   localparam int C = cmfuv_pkg::COORD_BITS;

   logic                  valid_ff, valid_in;
   cmfuv_pkg::stage_type  data_ff, data_in;

   logic [C-1:0]          ax, ay, az, m;
   logic signed [C:0]     xe, ye, ze, uc, vc;
   logic signed [C+1:0]   num_u_s, num_v_s;
   logic [C:0]            num_u, num_v, den;
   logic [2:0]            face;
   logic                  zero;

   assign xe = {in_data.dir_x[C-1], in_data.dir_x};
   assign ye = {in_data.dir_y[C-1], in_data.dir_y};
   assign ze = {in_data.dir_z[C-1], in_data.dir_z};

   assign ax = in_data.dir_x[C-1] ? C'(-in_data.dir_x) : C'(in_data.dir_x);
   assign ay = in_data.dir_y[C-1] ? C'(-in_data.dir_y) : C'(in_data.dir_y);
   assign az = in_data.dir_z[C-1] ? C'(-in_data.dir_z) : C'(in_data.dir_z);

   assign zero = (in_data.dir_x == '0) && (in_data.dir_y == '0) && (in_data.dir_z == '0);

   always_comb begin
      if (ax >= ay && ax >= az) begin
         m  = ax;
         vc = ye;
         if (!in_data.dir_x[C-1] && in_data.dir_x != '0) begin
            uc   = -ze;
            face = cmfuv_pkg::FACE_POS_X;
         end else begin
            uc   = ze;
            face = cmfuv_pkg::FACE_NEG_X;
         end
      end else if (ay >= az) begin
         m  = ay;
         uc = xe;
         if (!in_data.dir_y[C-1] && in_data.dir_y != '0) begin
            vc   = -ze;
            face = cmfuv_pkg::FACE_POS_Y;
         end else begin
            vc   = ze;
            face = cmfuv_pkg::FACE_NEG_Y;
         end
      end else begin
         m  = az;
         vc = ye;
         if (!in_data.dir_z[C-1] && in_data.dir_z != '0) begin
            uc   = xe;
            face = cmfuv_pkg::FACE_POS_Z;
         end else begin
            uc   = -xe;
            face = cmfuv_pkg::FACE_NEG_Z;
         end
      end
   end

   // numerators lie in [0, 2m]
   assign num_u_s = $signed({2'b00, m}) + {uc[C], uc};
   assign num_v_s = $signed({2'b00, m}) - {vc[C], vc};
   assign num_u   = num_u_s[C:0];
   assign num_v   = num_v_s[C:0];
   assign den     = {m, 1'b0};

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in      = in_valid;
         data_in.face  = zero ? cmfuv_pkg::FACE_POS_X : face;
         data_in.zero  = zero;
         data_in.sat_u = num_u >= den;
         data_in.sat_v = num_v >= den;
         data_in.den   = den;
         data_in.rem_u = num_u;
         data_in.rem_v = num_v;
         data_in.quo_u = '0;
         data_in.quo_v = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/cmfuv_div_cell.sv
`timescale 1ns / 1ps
// cmfuv_div_cell: one restoring division step for u and v, one quotient
// bit per cell, registered with its own handshake; uses cmfuv_pkg

module cmfuv_div_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  cmfuv_pkg::stage_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output cmfuv_pkg::stage_type  out_data
);

   localparam int C = cmfuv_pkg::COORD_BITS;
   localparam int F = cmfuv_pkg::FRAC_BITS;

   logic                  valid_ff, valid_in;
   cmfuv_pkg::stage_type  data_ff, data_in;

   logic [C+1:0]          sh_u, sh_v, den_x;
   logic                  bit_u, bit_v;

   assign den_x = {1'b0, in_data.den};
   assign sh_u  = {in_data.rem_u, 1'b0};
   assign sh_v  = {in_data.rem_v, 1'b0};
   assign bit_u = sh_u >= den_x;
   assign bit_v = sh_v >= den_x;

   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (in_ready) begin
         valid_in      = in_valid;
         data_in       = in_data;
         data_in.rem_v = bit_v ? (C+1)'(sh_v - den_x) : sh_v[C:0];
         data_in.quo_u = {in_data.quo_u[F-2:0], bit_u};
         data_in.quo_v = {in_data.quo_v[F-2:0], bit_v};
         data_in.rem_u = bit_u ? (C+1)'(sh_u - den_x) : sh_u[C:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// File: rtl/cube_map_face_uv_select.sv
`timescale 1ns / 1ps
// Cube map face select with face uv coordinates. A transaction enters every
// cycle while no stall on the result side holds off input, and its result
// passes through FRAC_BITS + 1 (17) register stages: one for face
// selection, then one per quotient bit in a chain of division cells
// that work on u and v side by side. Each stage holds its own transaction, so
// stalls on the result side fill bubbles before input is held off. An
// all-zero direction gives zero_vector set with face and coordinates zero.
// Depends on cmfuv_pkg, cmfuv_face_sel and cmfuv_div_cell.

module cube_map_face_uv_select (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  cmfuv_pkg::req_type  req_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output cmfuv_pkg::rsp_type  rsp_data
);

   localparam int F = cmfuv_pkg::FRAC_BITS;

   logic                  valid_chain [F+1];
   logic                  ready_chain [F+1];
   cmfuv_pkg::stage_type  data_chain  [F+1];
   cmfuv_pkg::stage_type  last;

   cmfuv_face_sel u_face_sel (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .out_valid (valid_chain[0]),
      .out_ready (ready_chain[0]),
      .out_data  (data_chain[0])
   );

   for (genvar i = 0; i < F; i++) begin : g_cell
      cmfuv_div_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[i]),
         .in_ready  (ready_chain[i]),
         .in_data   (data_chain[i]),
         .out_valid (valid_chain[i+1]),
         .out_ready (ready_chain[i+1]),
         .out_data  (data_chain[i+1])
      );
   end

   assign last           = data_chain[F];
   assign rsp_valid      = valid_chain[F];
   assign ready_chain[F] = rsp_ready;

   always_comb begin
      rsp_data.face_index  = last.face;
      rsp_data.zero_vector = last.zero;
      if (last.zero) begin
         rsp_data.tex_u = '0;
         rsp_data.tex_v = '0;
      end else begin
         rsp_data.tex_u = last.sat_u ? '1 : last.quo_u;
         rsp_data.tex_v = last.sat_v ? '1 : last.quo_v;
      end
   end

   a_zero_forces_zeros : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.zero_vector) |->
         (rsp_data.tex_u == '0 && rsp_data.tex_v == '0 &&
          rsp_data.face_index == cmfuv_pkg::FACE_POS_X))
      else $error("zero vector result carries nonzero fields");

   a_face_in_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.face_index <= cmfuv_pkg::FACE_NEG_Z))
      else $error("face index out of range");

   a_empty_after_reset : assert property (@(posedge clock)
      (!reset && $past(reset)) |-> !rsp_valid)
      else $error("result valid right after reset");

   a_ready_when_drained : assert property (@(posedge clock) disable iff (reset)
      (!valid_chain[0]) |-> req_ready)
      else $error("input held off with an empty first stage");

endmodule
